/* rtl/fwt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwt_pkg
// shared types and constants of the fenwick tree prefix-sum block
// ----------------------------------------------------------------------------
package fwt_pkg;

  localparam int TABLE_SIZE_DEF = 1024;
  localparam int IDX_W          = 10;
  localparam int DELTA_W        = 16;
  localparam int SUM_W          = 32;

  // one request as it waits between front and back
  typedef struct packed {
    logic                      is_query;
    logic [IDX_W-1:0]          index;
    logic signed [DELTA_W-1:0] delta;
  } q_entry_t;

  // conditions that hold back the front end
  typedef struct packed {
    logic clearing;
    logic q_full;
  } hold_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_DRAIN
  } bk_state_t;

endpackage
`default_nettype wire

/* rtl/fwt_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwt_front
// accepts request beats, drops adds beyond the table, clamps query indices
// ----------------------------------------------------------------------------
module fwt_front #(
  parameter int TABLE_SIZE = fwt_pkg::TABLE_SIZE_DEF
) (
  input  wire  logic                  clk,
  input  wire  logic                  rst,
  input  wire  logic                  s_tvalid,
  output logic                        s_tready,
  input  wire  logic [31:0]           s_tdata,
  input  wire  logic                  s_tuser,
  input  wire  fwt_pkg::hold_t        hold,
  output logic                        push,
  output fwt_pkg::q_entry_t           push_data
);
  import fwt_pkg::*;

  localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CW = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam logic [CW-1:0]    SIZE_C   = CW'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  logic [IDX_W-1:0]          idx;
  logic signed [DELTA_W-1:0] dlt;
  logic                      beyond;
  logic                      accept;

  assign idx      = s_tdata[IDX_W-1:0];
  assign dlt      = s_tdata[IDX_W+DELTA_W-1:IDX_W];
  assign beyond   = CW'(idx) >= SIZE_C;
  assign s_tready = !hold.clearing && !hold.q_full;
  assign accept   = s_tvalid && s_tready;

  // an add beyond the table changes nothing, so it never enters the queue
  always_comb begin
    push                = accept && (s_tuser || !beyond);
    push_data.is_query  = s_tuser;
    push_data.index     = (s_tuser && beyond) ? LAST_IDX : idx;
    push_data.delta     = dlt;
  end

`ifndef NO_ASSERTIONS
  a_no_push_in_clear: assert property (@(posedge clk) disable iff (rst)
    hold.clearing |-> !push)
    else $error("request queued during table clear");
  a_push_in_range: assert property (@(posedge clk) disable iff (rst)
    push |-> CW'(push_data.index) < SIZE_C)
    else $error("queued index outside the table");
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    hold.q_full |-> !push)
    else $error("push into a full queue");
`endif

endmodule
`default_nettype wire

/* rtl/fwt_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwt_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module fwt_queue (
  input  wire  logic              clk,
  input  wire  logic              rst,
  input  wire  logic              push,
  input  wire  fwt_pkg::q_entry_t push_data,
  output logic                    full,
  input  wire  logic              pop,
  output fwt_pkg::q_entry_t       pop_data,
  output logic                    empty
);
  import fwt_pkg::*;

  q_entry_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from an empty queue");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

/* rtl/fwt_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwt_back
// walks the partial-sum table for one request and holds the query result
// ----------------------------------------------------------------------------
module fwt_back #(
  parameter int TABLE_SIZE = fwt_pkg::TABLE_SIZE_DEF
) (
  input  wire  logic              clk,
  input  wire  logic              rst,
  input  wire  logic              q_empty,
  input  wire  fwt_pkg::q_entry_t q_data,
  output logic                    q_pop,
  output logic                    clearing,
  output logic                    m_tvalid,
  input  wire  logic              m_tready,
  output logic [31:0]             m_tdata
);
  import fwt_pkg::*;

  localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CW = (AW > IDX_W) ? AW : IDX_W;
  localparam logic [AW:0]   SIZE_C = (AW+1)'(TABLE_SIZE);
  localparam logic [AW-1:0] LAST_A = AW'(TABLE_SIZE - 1);

  logic [SUM_W-1:0] mem [TABLE_SIZE];

  bk_state_t        state;
  bk_state_t        state_next;
  logic [AW-1:0]    pos;
  logic             is_q;
  logic [SUM_W-1:0] delta_x;
  logic [SUM_W-1:0] acc;
  logic             rd_en;
  logic             rd_vld;
  logic [AW-1:0]    rd_addr;
  logic [SUM_W-1:0] rdata;
  logic             clr_active;
  logic [AW-1:0]    clr_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [SUM_W-1:0] wr_data;
  logic             out_load;
  logic [CW-1:0]    start_ext;

  logic [AW:0] pos_inc;
  logic [AW:0] add_nxt;
  logic [AW:0] q_mask;
  logic [AW:0] q_nxt;
  logic        more;
  logic [AW:0] nxt;

  assign clearing  = clr_active;
  assign start_ext = CW'(q_data.index);

  // add walks up with i | (i+1), query walks down with (r & (r+1)) - 1
  always_comb begin
    pos_inc = {1'b0, pos} + (AW+1)'(1);
    add_nxt = {1'b0, pos} | pos_inc;
    q_mask  = {1'b0, pos} & pos_inc;
    q_nxt   = q_mask - (AW+1)'(1);
    more    = is_q ? (q_mask != '0) : (add_nxt < SIZE_C);
    nxt     = is_q ? q_nxt : add_nxt;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty && !clr_active) begin
          q_pop      = 1'b1;
          state_next = BK_WALK;
        end
      end
      BK_WALK: begin
        rd_en = 1'b1;
        if (!more) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (!rd_vld && (!is_q || !m_tvalid || m_tready)) begin
          out_load   = is_q;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pos     <= start_ext[AW-1:0];
      is_q    <= q_data.is_query;
      delta_x <= SUM_W'(q_data.delta);
      acc     <= '0;
    end else begin
      if (rd_en && more) begin
        pos <= nxt[AW-1:0];
      end
      if (rd_vld && is_q) begin
        acc <= acc + rdata;
      end
    end
    rd_addr <= pos;
  end

  // write port: clearing sweep, else read-modify-write of the last entry read
  always_comb begin
    if (clr_active) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = rd_vld && !is_q;
      wr_addr = rd_addr;
      wr_data = rdata + delta_x;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld     <= 1'b0;
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else begin
      rd_vld <= rd_en;
      if (clr_active) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == LAST_A) begin
          clr_active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= acc;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> state == BK_IDLE)
    else $error("table walk during clear");
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    state == BK_WALK |-> {1'b0, pos} < SIZE_C)
    else $error("walk position outside the table");
  a_load_after_walk: assert property (@(posedge clk) disable iff (rst)
    out_load |-> is_q && !rd_vld && $past(state) != BK_IDLE)
    else $error("result loaded outside a finished query");
  a_no_write_on_query: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !clr_active) |-> !is_q && $past(rd_en))
    else $error("table write without a matching read");
`endif

endmodule
`default_nettype wire

/* rtl/fenwick_tree_add_prefix_sum.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fenwick_tree_add_prefix_sum
// zero-based fenwick tree: add a signed delta at an index, or return the
// wrapping 32-bit sum over indices 0 through the given one
// ----------------------------------------------------------------------------
// channel   dir  beat contents
// s_*       in   tuser: action (0 add, 1 query); tdata: index, delta
// m_*       out  tdata: prefix_sum, one beat per query
//
// one request walks n table entries, n <= log2(TABLE_SIZE) + 1 (11 at 1024
// entries), one read of the single table ram each cycle; the back end takes
// no new request until it is through with the walk of the last one.
// after reset the table is zeroed one entry a cycle, with s_tready low meanwhile.
// a two-entry queue lets the input keep taking beats while the back end walks;
// a stalled result beat holds the back end only at the end of the next query.
// ----------------------------------------------------------------------------
module fenwick_tree_add_prefix_sum #(
  parameter int TABLE_SIZE = fwt_pkg::TABLE_SIZE_DEF
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        s_tvalid,
  output logic              s_tready,
  input  wire  logic [31:0] s_tdata,  // index [9:0], delta [25:10], zero [31:26]
  input  wire  logic        s_tuser,  // action [0]
  output logic              m_tvalid,
  input  wire  logic        m_tready,
  output logic [31:0]       m_tdata   // prefix_sum [31:0]
);
  import fwt_pkg::*;

  hold_t    hold;
  logic     push;
  q_entry_t push_data;
  logic     q_full;
  logic     q_pop;
  q_entry_t q_data;
  logic     q_empty;
  logic     clearing;

  assign hold.clearing = clearing;
  assign hold.q_full   = q_full;

  fwt_front #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .hold      (hold),
    .push      (push),
    .push_data (push_data)
  );

  fwt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  fwt_back #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire
